/* hw/rtl/ath_pkg.sv */
package ath_pkg;

    // Window length and field widths.
    localparam int SAMPLES   = 10;
    localparam int SAMPLE_W  = 10;
    localparam int SUM_W     = 14;
    localparam int CNT_W     = $clog2(SAMPLES + 1);
    localparam int CFG_IDX_W = 8;
    localparam int PHASE_W   = 8;
    localparam int PHASES    = 4;
    localparam int PHASE_IDX_W = $clog2(PHASES);

    // Reciprocal of the window length, scaled by 2^SUM_W. The truncated
    // estimate is low by at most one and is fixed by one compare.
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SUM_W) / SAMPLES);

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAT_ON_BELOW  = 8'd0,
        CFG_COOL_ON_ABOVE  = 8'd1,
        CFG_COOL_OFF_BELOW = 8'd2,
        CFG_HEAT_OFF_ABOVE = 8'd3
    } t_cfg_idx;

    // Reset thresholds: 15, 35, 25 and 30 degrees at 2.054 counts per degree.
    localparam logic [SAMPLE_W-1:0] RST_HEAT_ON_BELOW  = 10'd31;
    localparam logic [SAMPLE_W-1:0] RST_COOL_ON_ABOVE  = 10'd71;
    localparam logic [SAMPLE_W-1:0] RST_COOL_OFF_BELOW = 10'd52;
    localparam logic [SAMPLE_W-1:0] RST_HEAT_OFF_ABOVE = 10'd61;

    // Stepper phase sequence, one nibble per step.
    function automatic logic [3:0] phase_pattern(input logic [PHASE_IDX_W-1:0] k);
        logic [3:0] p;
        case (k)
            2'd0:    p = 4'd9;
            2'd1:    p = 4'd12;
            2'd2:    p = 4'd6;
            default: p = 4'd3;
        endcase
        return p;
    endfunction

endpackage

/* hw/rtl/ath_ifs.sv */
// Sample stream into the thermostat.
interface ath_sample_if;
    import ath_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Result stream out of the thermostat.
interface ath_result_if;
    import ath_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] average;
    logic                heater_on;
    logic                cooler_on;
    logic [PHASE_W-1:0]  motor_phase;
    logic                last;

    modport source (output valid, output average, output heater_on, output cooler_on,
                    output motor_phase, output last, input ready);
    modport sink   (input valid, input average, input heater_on, input cooler_on,
                    input motor_phase, input last, output ready);
endinterface

// Register write channel.
interface ath_cfg_if;
    import ath_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SAMPLE_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/averaged_hysteresis_thermostat.sv */
// The result of a window passes through stages A, B and C after the transfer of its last sample.
// Throughput: one sample per cycle unless the pipeline stalls; a window gives one status result or four phase
// results, one per cycle while o_result.ready is high; samples stall only while stage A holds a
// closed window that cannot move. The sum stage, division stage and output register form a
// three-deep pipeline that stalls on output. Reset (synchronous, active low) clears the sum,
// count and flags, empties the pipeline and loads the reset thresholds.
module averaged_hysteresis_thermostat (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ath_sample_if.sink   i_sample,
    ath_cfg_if.sink      i_cfg,
    ath_result_if.source o_result
);
    import ath_pkg::*;

    // Threshold registers.
    logic [SAMPLE_W-1:0] r_heat_on_below;
    logic [SAMPLE_W-1:0] r_cool_on_above;
    logic [SAMPLE_W-1:0] r_cool_off_below;
    logic [SAMPLE_W-1:0] r_heat_off_above;

    // Accumulator.
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] n_sum;
    logic             win_end;
    logic             in_xfer;

    // Pipeline stages.
    logic             r_a_valid;
    logic [SUM_W-1:0] r_a_sum;
    logic             r_b_valid;
    logic [SUM_W-1:0] r_b_sum;
    logic [PROD_W-1:0] r_b_prod;
    logic             r_c_valid;
    logic [SAMPLE_W-1:0] r_c_avg;
    logic [PHASE_IDX_W-1:0] r_k;
    logic             r_heater;
    logic             r_cooler;

    logic a_free, b_free, c_free;
    logic out_last;
    logic out_xfer;

    // Division correction and flag update.
    logic [RECIP_W-1:0]  q_est;
    logic [RECIP_W-1:0]  q_mul;
    logic [RECIP_W-1:0]  rem;
    logic [RECIP_W-1:0]  quot;
    logic [SAMPLE_W-1:0] avg;
    logic                n_heater;
    logic                n_cooler;
    logic [3:0]          phase;

    // Stage handshakes: each stage moves when the one after it has room.
    assign out_last = (r_k == PHASE_IDX_W'(PHASES - 1)) || (!r_heater && !r_cooler);
    assign out_xfer = r_c_valid && o_result.ready;
    assign c_free   = !r_c_valid || (o_result.ready && out_last);
    assign b_free   = !r_b_valid || c_free;
    assign a_free   = !r_a_valid || b_free;
    assign in_xfer  = i_sample.valid && a_free;

    assign n_sum   = r_sum + SUM_W'(i_sample.sample);
    assign win_end = (r_count == CNT_W'(SAMPLES - 1));

    // Quotient estimate from the reciprocal product, then one correction step.
    always_comb begin
        q_est = r_b_prod[PROD_W-1:SUM_W];
        q_mul = RECIP_W'(q_est * RECIP_W'(SAMPLES));
        rem   = {1'b0, r_b_sum} - q_mul;
        quot  = (rem >= RECIP_W'(SAMPLES)) ? q_est + RECIP_W'(1) : q_est;
        avg   = quot[SAMPLE_W-1:0];
    end

    // Hysteresis rules, tried in priority order.
    always_comb begin
        n_heater = r_heater;
        n_cooler = r_cooler;
        if (!r_cooler && !r_heater && avg < r_heat_on_below) begin
            n_heater = 1'b1;
        end else if (!r_cooler && !r_heater && avg > r_cool_on_above) begin
            n_cooler = 1'b1;
        end else if (r_cooler && !r_heater && avg < r_cool_off_below) begin
            n_cooler = 1'b0;
        end else if (!r_cooler && r_heater && avg > r_heat_off_above) begin
            n_heater = 1'b0;
        end
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_on_below  <= RST_HEAT_ON_BELOW;
            r_cool_on_above  <= RST_COOL_ON_ABOVE;
            r_cool_off_below <= RST_COOL_OFF_BELOW;
            r_heat_off_above <= RST_HEAT_OFF_ABOVE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HEAT_ON_BELOW:  r_heat_on_below  <= i_cfg.data;
                CFG_COOL_ON_ABOVE:  r_cool_on_above  <= i_cfg.data;
                CFG_COOL_OFF_BELOW: r_cool_off_below <= i_cfg.data;
                CFG_HEAT_OFF_ABOVE: r_heat_off_above <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Accumulate samples and close the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (in_xfer) begin
            if (win_end) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Pipeline control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_heater  <= 1'b0;
            r_cooler  <= 1'b0;
            r_k       <= '0;
        end else begin
            if (a_free) begin
                r_a_valid <= in_xfer && win_end;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (c_free) begin
                r_c_valid <= r_b_valid;
                if (r_b_valid) begin
                    r_heater <= n_heater;
                    r_cooler <= n_cooler;
                    r_k      <= '0;
                end
            end else if (out_xfer) begin
                r_k <= r_k + PHASE_IDX_W'(1);
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_sum <= n_sum;
        end
        if (b_free) begin
            r_b_sum  <= r_a_sum;
            r_b_prod <= PROD_W'(r_a_sum) * PROD_W'(RECIP);
        end
        if (c_free && r_b_valid) begin
            r_c_avg <= avg;
        end
    end

    // Result drive.
    assign phase = phase_pattern(r_k);

    always_comb begin
        o_result.valid     = r_c_valid;
        o_result.average   = r_c_avg;
        o_result.heater_on = r_heater;
        o_result.cooler_on = r_cooler;
        o_result.last      = out_last;
        if (r_heater) begin
            o_result.motor_phase = {phase, 4'd0};
        end else if (r_cooler) begin
            o_result.motor_phase = {4'd0, phase};
        end else begin
            o_result.motor_phase = '0;
        end
    end

    assign i_sample.ready = a_free;
    assign i_cfg.ready    = 1'b1;

endmodule

/* hw/rtl/ath_checker.sv */
module ath_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic [ath_pkg::SAMPLE_W-1:0] i_average,
    input logic                         i_heater_on,
    input logic                         i_cooler_on,
    input logic [ath_pkg::PHASE_W-1:0]  i_motor_phase,
    input logic                         i_last
);
    import ath_pkg::*;

    // The two flags never show together.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_heater_on && i_cooler_on))
        else $error("heater and cooler both on");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_average) && $stable(i_motor_phase)
                                && $stable(i_last))
        else $error("stalled result changed");

    // Heater words sit in the high nibble, cooler words in the low nibble.
    a_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_heater_on || i_cooler_on) |->
            (i_heater_on ? (i_motor_phase[3:0] == 4'd0 && i_motor_phase[7:4] != 4'd0)
                         : (i_motor_phase[7:4] == 4'd0 && i_motor_phase[3:0] != 4'd0)))
        else $error("phase word in wrong nibble");

    // A status result is a lone, idle, final result.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_heater_on && !i_cooler_on |-> i_last && i_motor_phase == '0)
        else $error("bad status result");

    // Within a window the next phase word follows at once with the same average.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last |=> i_valid && $stable(i_average))
        else $error("phase burst broken");

endmodule

bind averaged_hysteresis_thermostat ath_checker u_ath_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_result.valid),
    .i_ready       (o_result.ready),
    .i_average     (o_result.average),
    .i_heater_on   (o_result.heater_on),
    .i_cooler_on   (o_result.cooler_on),
    .i_motor_phase (o_result.motor_phase),
    .i_last        (o_result.last)
);
